[hw/rtl/lpbcf_pkg.sv]
// Shared types and constants for the lidar point body crop filter.
// No dependencies; used by the top level by scoped names.
`default_nettype none

package lpbcf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int COORD_W    = 19;
    localparam int NUM_STAGES = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_X   = 3'd0,
        CFG_ROT_Y   = 3'd1,
        CFG_ROT_Z   = 3'd2,
        CFG_TRANS   = 3'd3,
        CFG_RADIUS  = 3'd4,
        CFG_RATIO   = 3'd5
    } cfg_idx_t;

    localparam logic [47:0]        ROT_X_RST  = 48'h0000_0000_4000;
    localparam logic [47:0]        ROT_Y_RST  = 48'h0000_4000_0000;
    localparam logic [47:0]        ROT_Z_RST  = 48'h4000_0000_0000;
    localparam logic [59:0]        TRANS_RST  = 60'd0;
    localparam logic [17:0]        RADIUS_RST = 18'd338;
    localparam logic signed [15:0] RATIO_RST  = 16'sd2476;

    // 1 m in robot frame height
    localparam logic signed [23:0] ONE_M = 24'sd1024;
    // 25*d2 < 2304^2  <=>  d2 <= 212336
    localparam logic [47:0] NEAR_D2_MAX = 48'd212336;

    typedef struct packed {
        logic        last;
        logic [18:0] z;
        logic [18:0] y;
        logic [18:0] x;
    } pt_t;

endpackage

`default_nettype wire

[hw/rtl/lidar_point_body_crop_filter_unit.sv]
// Lidar point body crop filter: rotate/translate, then radius and elevation crop.
// Depends on lpbcf_pkg.
//
//  channel | ports                         | payload
//  --------+-------------------------------+------------------------------------
//  in      | s_tvalid s_tready s_tdata     | tdata: px, py, pz; tlast: last_in
//  out     | m_tvalid m_tready m_tdata     | tdata: qx, qy, qz; tuser: keep;
//          | m_tuser m_tlast               | tlast: last_out
//  cfg     | cfg_valid cfg_ready           | cfg_index, cfg_data
//
// One point per cycle sustained while the sink keeps m_tready high; each point passes the stages below in order.
// Stages: products/squares, sums, wide squares and ratio partials,
// final adds, compares into the output register.
// Each stage holds its request while the next is full; a stall loses nothing.
// aresetn clears valid bits and restores register defaults. cfg_ready is always high.
`default_nettype none

module lidar_point_body_crop_filter_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [63:0]                       s_tdata,   // px[18:0], py, pz, zero pad
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [63:0]                            m_tdata,   // qx[18:0], qy, qz, zero pad
    output logic                                   m_tuser,   // keep
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lpbcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lpbcf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int NS = lpbcf_pkg::NUM_STAGES;

    // configuration
    logic [47:0]        rot_reg [3];
    logic [59:0]        trans_reg;
    logic [17:0]        radius_reg;
    logic signed [15:0] ratio_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_reg[0] <= lpbcf_pkg::ROT_X_RST;
            rot_reg[1] <= lpbcf_pkg::ROT_Y_RST;
            rot_reg[2] <= lpbcf_pkg::ROT_Z_RST;
            trans_reg  <= lpbcf_pkg::TRANS_RST;
            radius_reg <= lpbcf_pkg::RADIUS_RST;
            ratio_reg  <= lpbcf_pkg::RATIO_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (lpbcf_pkg::cfg_idx_t'(cfg_index))
                lpbcf_pkg::CFG_ROT_X:  rot_reg[0] <= cfg_data[47:0];
                lpbcf_pkg::CFG_ROT_Y:  rot_reg[1] <= cfg_data[47:0];
                lpbcf_pkg::CFG_ROT_Z:  rot_reg[2] <= cfg_data[47:0];
                lpbcf_pkg::CFG_TRANS:  trans_reg  <= cfg_data[59:0];
                lpbcf_pkg::CFG_RADIUS: radius_reg <= cfg_data[17:0];
                lpbcf_pkg::CFG_RATIO:  ratio_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // flow control
    logic [NS:1]         v_reg;
    logic [NS:1]         en;
    lpbcf_pkg::pt_t      pt_reg [1:NS];
    lpbcf_pkg::pt_t      pt_in;

    always_comb begin
        en[NS] = !v_reg[NS] || m_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[1];
    assign pt_in    = '{last: s_tlast, z: s_tdata[56:38], y: s_tdata[37:19],
                        x: s_tdata[18:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[1]) v_reg[1] <= s_tvalid;
            for (int k = 2; k <= NS; k++) begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) pt_reg[1] <= pt_in;
        for (int k = 2; k <= NS; k++) begin
            if (en[k]) pt_reg[k] <= pt_reg[k-1];
        end
    end

    // stage 1: coefficient products with floor shift, coordinate squares, ratio square
    logic signed [20:0] p_reg  [3][3];
    logic signed [20:0] p_next [3][3];
    logic [36:0]        x2_reg, y2_reg, z2_1_reg;
    logic [36:0]        x2_next, y2_next, z2_1_next;
    logic [30:0]        e2_1_reg, e2_1_next;

    always_comb begin
        logic signed [18:0] c_in [3];
        logic signed [34:0] prod;
        logic signed [37:0] sq [3];
        logic signed [31:0] esq;
        c_in[0] = $signed(pt_in.x);
        c_in[1] = $signed(pt_in.y);
        c_in[2] = $signed(pt_in.z);
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod         = $signed(rot_reg[r][16*c +: 16]) * c_in[c];
                p_next[r][c] = prod[34:14];
            end
        end
        for (int c = 0; c < 3; c++) begin
            sq[c] = c_in[c] * c_in[c];
        end
        x2_next   = sq[0][36:0];
        y2_next   = sq[1][36:0];
        z2_1_next = sq[2][36:0];
        esq       = ratio_reg * ratio_reg;
        e2_1_next = esq[30:0];
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            p_reg    <= p_next;
            x2_reg   <= x2_next;
            y2_reg   <= y2_next;
            z2_1_reg <= z2_1_next;
            e2_1_reg <= e2_1_next;
        end
    end

    // stage 2: row sums minus translation, horizontal raw square sum and its zero flag
    logic signed [23:0] rx_reg, ry_reg, rz_2_reg;
    logic signed [23:0] rx_next, ry_next, rz_2_next;
    logic [37:0]        s_reg, s_next;
    logic               sz_2_reg, sz_2_next;
    logic [36:0]        z2_2_reg;
    logic [30:0]        e2_2_reg;

    always_comb begin
        logic signed [23:0] acc [3];
        for (int r = 0; r < 3; r++) begin
            acc[r] = 24'(p_reg[r][0]) + 24'(p_reg[r][1]) + 24'(p_reg[r][2])
                   - 24'($signed(trans_reg[20*r +: 20]));
        end
        rx_next   = acc[0];
        ry_next   = acc[1];
        rz_2_next = acc[2];
        s_next    = {1'b0, x2_reg} + {1'b0, y2_reg};
        sz_2_next = (x2_reg == '0) && (y2_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            rz_2_reg <= rz_2_next;
            s_reg    <= s_next;
            sz_2_reg <= sz_2_next;
            z2_2_reg <= z2_1_reg;
            e2_2_reg <= e2_1_reg;
        end
    end

    // stage 3: robot-frame squares, radius square, ratio partial products
    logic [46:0]        rx2_reg, ry2_reg, rx2_next, ry2_next;
    logic [35:0]        r2_3_reg, r2_3_next;
    logic [49:0]        es_lo_reg, es_hi_reg, es_lo_next, es_hi_next;
    logic signed [23:0] rz_3_reg;
    logic               sz_3_reg;
    logic [36:0]        z2_3_reg;

    always_comb begin
        logic signed [47:0] sqx, sqy;
        sqx        = rx_reg * rx_reg;
        sqy        = ry_reg * ry_reg;
        rx2_next   = sqx[46:0];
        ry2_next   = sqy[46:0];
        r2_3_next  = radius_reg * radius_reg;
        es_lo_next = e2_2_reg * s_reg[18:0];
        es_hi_next = e2_2_reg * s_reg[37:19];
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            rx2_reg   <= rx2_next;
            ry2_reg   <= ry2_next;
            r2_3_reg  <= r2_3_next;
            es_lo_reg <= es_lo_next;
            es_hi_reg <= es_hi_next;
            rz_3_reg  <= rz_2_reg;
            sz_3_reg  <= sz_2_reg;
            z2_3_reg  <= z2_2_reg;
        end
    end

    // stage 4: horizontal distance square, full ratio product
    logic [47:0]        d2_reg, d2_next;
    logic [68:0]        es_reg, es_next;
    logic [35:0]        r2_4_reg;
    logic signed [23:0] rz_4_reg;
    logic               sz_4_reg;
    logic [36:0]        z2_4_reg;

    always_comb begin
        d2_next = {1'b0, rx2_reg} + {1'b0, ry2_reg};
        es_next = {es_hi_reg, 19'd0} + {19'd0, es_lo_reg};
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            d2_reg   <= d2_next;
            es_reg   <= es_next;
            r2_4_reg <= r2_3_reg;
            rz_4_reg <= rz_3_reg;
            sz_4_reg <= sz_3_reg;
            z2_4_reg <= z2_3_reg;
        end
    end

    // stage 5: crop decisions into the output register
    logic keep_reg, keep_next;

    always_comb begin
        logic [68:0] zq;
        logic        zneg;
        logic        below;
        logic        drop_body;
        logic        drop_near;
        zq   = {4'd0, z2_4_reg, 28'd0};
        zneg = pt_reg[4].z[18];
        priority if (sz_4_reg) begin
            below = zneg;
        end else if (!ratio_reg[15]) begin
            below = zneg || (zq < es_reg);
        end else begin
            below = zneg && (zq > es_reg);
        end
        drop_body = (d2_reg < {12'd0, r2_4_reg}) && (rz_4_reg < lpbcf_pkg::ONE_M);
        drop_near = (d2_reg <= lpbcf_pkg::NEAR_D2_MAX) && rz_4_reg[23] && below;
        keep_next = !(drop_body || drop_near);
    end

    always_ff @(posedge aclk) begin
        if (en[5]) keep_reg <= keep_next;
    end

    assign m_tvalid = v_reg[NS];
    assign m_tdata  = {7'd0, pt_reg[NS].z, pt_reg[NS].y, pt_reg[NS].x};
    assign m_tuser  = keep_reg;
    assign m_tlast  = pt_reg[NS].last;

endmodule

`default_nettype wire

[hw/rtl/lpbcf_checker.sv]
// Port-level checks for the body crop filter, bound to the top level.
// Depends on lidar_point_body_crop_filter_unit port list only.
`default_nettype none

module lpbcf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // stalled request holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped under stall");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output payload changed under stall");

    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid right after reset");

    // input back-pressure only comes from a full, stalled output
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    // an accepted request reaches the output when the sink keeps taking
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready ##1 m_tready ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("accepted request did not reach output in time");

endmodule

bind lidar_point_body_crop_filter_unit lpbcf_checker u_lpbcf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for lidar_point_body_crop_filter_unit: directed table, then random
// phases with random or fixed setups and idling; results checked against an in-bench predictor or table.
// Depends on lpbcf_pkg and the filter RTL.
`default_nettype none

module tb;

    localparam longint METER      = 1024;
    localparam longint NEAR_BOUND = 2304 * 2304;  // 25*d2 vs (0.45 m * 5)^2
    localparam int     WATCHDOG   = 4000;
    localparam int     PHASES     = 6;
    localparam int     PHASE_PTS  = 125;
    localparam logic [2:0] IDX_SPARE6 = 3'd6;
    localparam logic [2:0] IDX_SPARE7 = 3'd7;

    typedef enum logic { ROW_POINT, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  idx;
        logic [63:0] data;
        logic [18:0] x;
        logic [18:0] y;
        logic [18:0] z;
        logic        last;
        logic        typed;
        logic        keep;
    } step_t;

    typedef struct packed {
        logic        keep;
        logic [18:0] x;
        logic [18:0] y;
        logic [18:0] z;
        logic        last;
    } verdict_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    logic [47:0] rot_x      = lpbcf_pkg::ROT_X_RST;
    logic [47:0] rot_y      = lpbcf_pkg::ROT_Y_RST;
    logic [47:0] rot_z      = lpbcf_pkg::ROT_Z_RST;
    logic [59:0] offset_xyz = lpbcf_pkg::TRANS_RST;
    logic [17:0] radius_cfg = lpbcf_pkg::RADIUS_RST;
    logic [15:0] ratio_cfg  = lpbcf_pkg::RATIO_RST;

    verdict_t verdicts_due [$];
    int       errors       = 0;
    int       quiet_cycles = 0;
    int       src_idle     = 0;
    int       sink_stall   = 0;
    bit       long_hold    = 1'b0;
    bit       held_once    = 1'b0;
    int       hold_left    = 0;

    int src_idle_plan   [PHASES] = '{0, 79, 0, 27, 0, 10};
    int sink_stall_plan [PHASES] = '{0, 0, 79, 27, 0, 10};

    step_t script [25];

    lidar_point_body_crop_filter_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint rotate_row(logic [47:0] row, longint x, longint y, longint z);
        longint a, b, c;
        a = $signed(row[15:0]);
        b = $signed(row[31:16]);
        c = $signed(row[47:32]);
        return ((a * x) >>> 14) + ((b * y) >>> 14) + ((c * z) >>> 14);
    endfunction

    // z / hypot(x, y) < e / 2^14, exact; z/0 is -inf for z < 0, else +inf or NaN
    function automatic bit under_elevation(longint x, longint y, longint z, longint e);
        logic [127:0] s, lhs, rhs;
        s = x * x + y * y;
        if (s == 0)
            return z < 0;
        lhs = z * z;
        lhs = lhs << 28;
        rhs = e * e;
        rhs = rhs * s;
        if (e >= 0)
            return (z < 0) || (lhs < rhs);
        return (z < 0) && (lhs > rhs);
    endfunction

    function automatic logic body_crop_keep(logic [18:0] px, logic [18:0] py, logic [18:0] pz);
        longint x, y, z, rx, ry, rz, d2, r;
        x  = $signed(px);
        y  = $signed(py);
        z  = $signed(pz);
        rx = rotate_row(rot_x, x, y, z) - longint'($signed(offset_xyz[19:0]));
        ry = rotate_row(rot_y, x, y, z) - longint'($signed(offset_xyz[39:20]));
        rz = rotate_row(rot_z, x, y, z) - longint'($signed(offset_xyz[59:40]));
        d2 = rx * rx + ry * ry;
        r  = radius_cfg;
        if (d2 < r * r && rz < METER)
            return 1'b0;
        if (25 * d2 < NEAR_BOUND && rz < 0 &&
            under_elevation(x, y, z, longint'($signed(ratio_cfg))))
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [18:0] corner_coord();
        case ($urandom_range(4))
            0: return 19'h40000;
            1: return 19'h3FFFF;
            2: return 19'h00000;
            3: return 19'h7FFFF;
            default: return 19'h00001;
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            lpbcf_pkg::CFG_ROT_X:  rot_x      = data[47:0];
            lpbcf_pkg::CFG_ROT_Y:  rot_y      = data[47:0];
            lpbcf_pkg::CFG_ROT_Z:  rot_z      = data[47:0];
            lpbcf_pkg::CFG_TRANS:  offset_xyz = data[59:0];
            lpbcf_pkg::CFG_RADIUS: radius_cfg = data[17:0];
            lpbcf_pkg::CFG_RATIO:  ratio_cfg  = data[15:0];
            default: ;
        endcase
    endtask

    task automatic send_point(logic [18:0] x, logic [18:0] y, logic [18:0] z, logic last,
                              logic typed, logic typed_keep);
        verdict_t v;
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, z, y, x};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        v.keep = typed ? typed_keep : body_crop_keep(x, y, z);
        v.x    = x;
        v.y    = y;
        v.z    = z;
        v.last = last;
        verdicts_due = {verdicts_due, v};
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0) @(posedge aclk);
    endtask

    // receiver: random stalls, plus one long hold-off to back up the pipe
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (long_hold && !held_once) begin
            hold_left <= 400;
            held_once <= 1'b1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall);
        end
    end

    always @(posedge aclk) begin
        verdict_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.keep = m_tuser;
            got.x    = m_tdata[18:0];
            got.y    = m_tdata[37:19];
            got.z    = m_tdata[56:38];
            got.last = m_tlast;
            if (verdicts_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result keep=%0d q=(%0d,%0d,%0d) last=%0d", $time,
                         got.keep, $signed(got.x), $signed(got.y), $signed(got.z), got.last);
            end else begin
                want = verdicts_due.pop_front();
                if (got !== want || m_tdata[63:57] !== 7'd0) begin
                    errors++;
                    $display({"%0t: mismatch expected keep=%0d q=(%0d,%0d,%0d) last=%0d,",
                              " got keep=%0d q=(%0d,%0d,%0d) last=%0d pad=%h"},
                             $time, want.keep, $signed(want.x), $signed(want.y),
                             $signed(want.z), want.last, got.keep, $signed(got.x),
                             $signed(got.y), $signed(got.z), got.last, m_tdata[63:57]);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [18:0] x, y, z;
        logic [63:0] vals [6];
        int          mode;

        script = '{
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd0, 19'sd0, 19'sd0, 1'b0, 1'b1, 1'b0},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd0, 19'sd0, 19'sd1024, 1'b1, 1'b1, 1'b1},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd0, 19'sd0, 19'sd1023, 1'b0, 1'b1, 1'b0},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd337, 19'sd0, 19'sd0, 1'b0, 1'b1, 1'b0},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd0, -19'sd338, 19'sd0, 1'b0, 1'b1, 1'b1},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'h40000, 19'h40000, 19'h40000, 1'b1, 1'b1, 1'b1},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd262143, 19'sd262143, 19'sd262143, 1'b0, 1'b1, 1'b1},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd400, 19'sd0, -19'sd100, 1'b0, 1'b1, 1'b0},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd460, 19'sd0, -19'sd10, 1'b0, 1'b1, 1'b0},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd461, 19'sd0, -19'sd10, 1'b0, 1'b1, 1'b1},
            '{ROW_REG, lpbcf_pkg::CFG_RADIUS, 64'hFFFF_FFFF_FFFC_0000,
              19'sd0, 19'sd0, 19'sd0, 1'b0, 1'b0, 1'b0},
            '{ROW_REG, lpbcf_pkg::CFG_TRANS, 64'hF000_6400_0000_0000,
              19'sd0, 19'sd0, 19'sd0, 1'b0, 1'b0, 1'b0},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd0, 19'sd0, 19'sd50, 1'b0, 1'b1, 1'b1},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd0, 19'sd0, -19'sd5, 1'b0, 1'b1, 1'b0},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd0, 19'sd0, 19'sd0, 1'b1, 1'b1, 1'b1},
            '{ROW_REG, lpbcf_pkg::CFG_RATIO, 64'h0000_0000_0000_E000,
              19'sd0, 19'sd0, 19'sd0, 1'b0, 1'b0, 1'b0},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd100, 19'sd0, -19'sd40, 1'b0, 1'b0, 1'b0},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd100, 19'sd0, -19'sd60, 1'b0, 1'b0, 1'b0},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd100, 19'sd0, 19'sd10, 1'b0, 1'b0, 1'b0},
            '{ROW_REG, IDX_SPARE7, 64'hFFFF_FFFF_FFFF_FFFF,
              19'sd0, 19'sd0, 19'sd0, 1'b0, 1'b0, 1'b0},
            '{ROW_REG, lpbcf_pkg::CFG_ROT_X, 64'hFFFF_0000_C000_0000,
              19'sd0, 19'sd0, 19'sd0, 1'b0, 1'b0, 1'b0},
            '{ROW_REG, lpbcf_pkg::CFG_ROT_Y, 64'h0000_0000_0000_4000,
              19'sd0, 19'sd0, 19'sd0, 1'b0, 1'b0, 1'b0},
            '{ROW_REG, lpbcf_pkg::CFG_ROT_Z, 64'h0000_7FFF_0000_0000,
              19'sd0, 19'sd0, 19'sd0, 1'b0, 1'b0, 1'b0},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'sd300, -19'sd200, -19'sd30, 1'b1, 1'b0, 1'b0},
            '{ROW_POINT, lpbcf_pkg::CFG_ROT_X, 64'd0,
              19'h40000, 19'sd262143, 19'h40000, 1'b0, 1'b0, 1'b0}
        };

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_REG) begin
                drain();
                write_reg(script[i].idx, script[i].data);
            end else begin
                send_point(script[i].x, script[i].y, script[i].z, script[i].last,
                           script[i].typed, script[i].keep);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    vals[0] = {16'd0, lpbcf_pkg::ROT_X_RST};
                    vals[1] = {16'd0, lpbcf_pkg::ROT_Y_RST};
                    vals[2] = {16'd0, lpbcf_pkg::ROT_Z_RST};
                    vals[3] = {4'd0, lpbcf_pkg::TRANS_RST};
                    vals[4] = {46'd0, lpbcf_pkg::RADIUS_RST};
                    vals[5] = 64'h0000_0000_0000_7FFF;
                end
                4: foreach (vals[r]) vals[r] = '1;
                5: foreach (vals[r]) vals[r] = '0;
                default: begin
                    for (int r = 0; r < 3; r++) begin
                        vals[r] = {$urandom, $urandom};
                        for (int c = 0; c < 3; c++)
                            vals[r][16*c +: 16] = ($urandom_range(3) == 0) ? 16'($urandom) :
                                                  16'($urandom_range(32768) - 16384);
                    end
                    vals[3] = {$urandom, $urandom};
                    for (int c = 0; c < 3; c++)
                        vals[3][20*c +: 20] = 20'($urandom_range(1200) - 600);
                    vals[4] = {$urandom, $urandom};
                    vals[4][17:0] = 18'($urandom_range(1500));
                    vals[5] = {$urandom, $urandom};
                    if (ph == 3)
                        vals[5][15:0] = 16'h8000;
                end
            endcase
            for (int r = 0; r < 6; r++)
                write_reg(3'(r), vals[r]);
            write_reg(IDX_SPARE6, {$urandom, $urandom});
            write_reg(IDX_SPARE7, {$urandom, $urandom});

            src_idle   = src_idle_plan[ph];
            sink_stall = sink_stall_plan[ph];
            long_hold  = (ph == 4);
            for (int n = 0; n < PHASE_PTS; n++) begin
                mode = $urandom_range(9);
                if (mode < 2) begin
                    x = 19'($urandom);
                    y = 19'($urandom);
                    z = 19'($urandom);
                end else if (mode == 2) begin
                    x = corner_coord();
                    y = corner_coord();
                    z = corner_coord();
                end else begin
                    // near the body, where both crop rules bite
                    x = 19'($urandom_range(2000) - 1000);
                    y = 19'($urandom_range(2000) - 1000);
                    z = 19'($urandom_range(2600) - 1300);
                end
                send_point(x, y, z, $urandom_range(7) == 0, 1'b0, 1'b0);
            end
            long_hold = 1'b0;
        end

        drain();
        repeat (2 * lpbcf_pkg::NUM_STAGES) @(posedge aclk);
        if (errors == 0 && verdicts_due.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
